// ----- hdl/cca_pkg.sv -----
// shared types, constants and reciprocal factors for the capacitance counter
package cca_pkg;

    localparam int TOTAL_WIDTH_DEF = 26;

    // overflow step, range limits and scale
    localparam int OVF_STEP  = 65536;
    localparam int PF_LIMIT  = 34;
    localparam int NF_LIMIT  = 33334;
    localparam int UF_LIMIT  = 33333333;
    localparam int PF_SCALE  = 30;

    // totals that are in range fit this many bits
    localparam int RANGE_W = 25;
    // numerator 3*total, below 100000000
    localparam int NUM_W   = RANGE_W + 2;
    // scaled value, 0..999
    localparam int VAL_W   = 10;
    localparam int DIGIT_W = 4;

    // reciprocal factors, exact for every numerator that their own range produces
    localparam int RECIP_W  = 28;
    localparam int PROD_W   = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] NF_RECIP = 28'd167773;    // ceil(2^24 / 100)
    localparam logic [RECIP_W-1:0] UF_RECIP = 28'd175921861; // ceil(2^44 / 100000)
    localparam int NF_SHIFT = 24;
    localparam int UF_SHIFT = 44;

    typedef enum logic [1:0] {
        UNIT_PF = 2'd0,
        UNIT_NF = 2'd1,
        UNIT_UF = 2'd2
    } unit_t;

    // control that travels with a reading down the pipeline
    typedef struct packed {
        logic  valid;
        unit_t unit;
        logic  ok;
    } cca_ctrl_t;

endpackage

// ----- hdl/capacitance_count_autorange.sv -----
// top level of the capacitance counter with automatic range selection
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_kind, s_captured_count
//  m_        out        m_valid / m_ready   m_digit_hundreds, m_digit_tens,
//                                           m_digit_ones, m_unit_code, m_in_range
//
// one item a cycle is accepted unless a result waits; each capture item yields one reading
// the pipeline is tick accumulator, range select, reciprocal multiply, digit split
// reset clears the tick total and every stage valid
// while a result waits on m_ready the whole pipeline holds and s_ready is low;
// it drops only when the result register is full and not taken
module capacitance_count_autorange #(
    parameter int TOTAL_WIDTH = cca_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [15:0]                 s_captured_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cca_pkg::DIGIT_W-1:0] m_digit_hundreds,
    output logic [cca_pkg::DIGIT_W-1:0] m_digit_tens,
    output logic [cca_pkg::DIGIT_W-1:0] m_digit_ones,
    output logic [1:0]                  m_unit_code,
    output logic                        m_in_range
);

    // pipeline moves whenever the result register is free or being emptied
    logic                        advance;
    logic                        accept;
    logic                        cap_valid;
    logic [TOTAL_WIDTH-1:0]      cap_total;
    cca_pkg::cca_ctrl_t          scale_ctrl;
    logic [cca_pkg::NUM_W-1:0]   scale_num;
    cca_pkg::cca_ctrl_t          div_ctrl;
    logic [cca_pkg::VAL_W-1:0]   div_val;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    // overflow items only grow the total; capture items enter the pipeline
    cca_accum #(
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .advance       (advance),
        .kind          (s_kind),
        .captured_count(s_captured_count),
        .cap_valid     (cap_valid),
        .cap_total     (cap_total)
    );

    // pick pF, nF or uF and form the numerator
    cca_scale #(
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .cap_valid(cap_valid),
        .cap_total(cap_total),
        .ctrl     (scale_ctrl),
        .num      (scale_num)
    );

    // divide nF numerators by 100 and uF numerators by 100000; pF passes through
    cca_divide u_divide (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(advance),
        .ctrl_in(scale_ctrl),
        .num    (scale_num),
        .ctrl   (div_ctrl),
        .val    (div_val)
    );

    // three decimal digits into the result register
    cca_digits u_digits (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .ctrl_in  (div_ctrl),
        .val      (div_val),
        .out_valid(m_valid),
        .hundreds (m_digit_hundreds),
        .tens     (m_digit_tens),
        .ones     (m_digit_ones),
        .unit_code(m_unit_code),
        .in_range (m_in_range)
    );

endmodule

// ----- hdl/cca_accum.sv -----
// running tick total with saturation, and the capture register
module cca_accum #(
    parameter int TOTAL_WIDTH = cca_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   advance,
    input  logic                   kind,
    input  logic [15:0]            captured_count,
    output logic                   cap_valid,
    output logic [TOTAL_WIDTH-1:0] cap_total
);

    logic [TOTAL_WIDTH-1:0] tick_total_reg, tick_total_next;
    logic                   cap_valid_reg, cap_valid_next;
    logic [TOTAL_WIDTH-1:0] cap_total_reg, cap_total_next;
    logic [TOTAL_WIDTH-1:0] amount;
    logic [TOTAL_WIDTH:0]   sum;
    logic [TOTAL_WIDTH-1:0] sat_total;

    always_comb begin
        amount = kind ? TOTAL_WIDTH'(captured_count) : TOTAL_WIDTH'(cca_pkg::OVF_STEP);
        sum    = {1'b0, tick_total_reg} + {1'b0, amount};
        sat_total = sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : sum[TOTAL_WIDTH-1:0];

        tick_total_next = tick_total_reg;
        cap_valid_next  = cap_valid_reg;
        cap_total_next  = cap_total_reg;
        if (accept) begin
            // a capture clears the total once it is accepted
            tick_total_next = kind ? '0 : sat_total;
        end
        if (advance) begin
            cap_valid_next = accept && kind;
            cap_total_next = sat_total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_total_reg <= '0;
            cap_valid_reg  <= 1'b0;
        end else begin
            tick_total_reg <= tick_total_next;
            cap_valid_reg  <= cap_valid_next;
        end
        cap_total_reg <= cap_total_next;
    end

    assign cap_valid = cap_valid_reg;
    assign cap_total = cap_total_reg;

endmodule

// ----- hdl/cca_scale.sv -----
// range selection and scaled numerator
module cca_scale #(
    parameter int TOTAL_WIDTH = cca_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      cap_valid,
    input  logic [TOTAL_WIDTH-1:0]    cap_total,
    output cca_pkg::cca_ctrl_t        ctrl,
    output logic [cca_pkg::NUM_W-1:0] num
);

    cca_pkg::cca_ctrl_t        ctrl_reg, ctrl_next;
    logic [cca_pkg::NUM_W-1:0] num_reg, num_next;
    cca_pkg::cca_ctrl_t        sel;
    logic [cca_pkg::NUM_W-1:0] sel_num;
    logic [cca_pkg::RANGE_W-1:0] t_low;

    always_comb begin
        t_low     = cap_total[cca_pkg::RANGE_W-1:0];
        sel.valid = cap_valid;
        sel.ok    = 1'b1;
        if (cap_total < TOTAL_WIDTH'(cca_pkg::PF_LIMIT)) begin
            sel.unit = cca_pkg::UNIT_PF;
            sel_num  = cca_pkg::NUM_W'(t_low[5:0]) * cca_pkg::NUM_W'(cca_pkg::PF_SCALE);
        end else if (cap_total < TOTAL_WIDTH'(cca_pkg::NF_LIMIT)) begin
            sel.unit = cca_pkg::UNIT_NF;
            sel_num  = cca_pkg::NUM_W'(t_low) * cca_pkg::NUM_W'(3);
        end else if (cap_total < TOTAL_WIDTH'(cca_pkg::UF_LIMIT)) begin
            sel.unit = cca_pkg::UNIT_UF;
            sel_num  = cca_pkg::NUM_W'(t_low) * cca_pkg::NUM_W'(3);
        end else begin
            // out of range: zero reading on the pF path
            sel.unit = cca_pkg::UNIT_PF;
            sel.ok   = 1'b0;
            sel_num  = '0;
        end
        ctrl_next = advance ? sel : ctrl_reg;
        num_next  = advance ? sel_num : num_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
        num_reg <= num_next;
    end

    assign ctrl = ctrl_reg;
    assign num  = num_reg;

endmodule

// ----- hdl/cca_divide.sv -----
// constant division by reciprocal multiply
module cca_divide (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  cca_pkg::cca_ctrl_t        ctrl_in,
    input  logic [cca_pkg::NUM_W-1:0] num,
    output cca_pkg::cca_ctrl_t        ctrl,
    output logic [cca_pkg::VAL_W-1:0] val
);

    cca_pkg::cca_ctrl_t          ctrl_reg, ctrl_next;
    logic [cca_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [cca_pkg::RECIP_W-1:0] recip;
    logic [cca_pkg::PROD_W-1:0]  prod;
    logic [cca_pkg::VAL_W-1:0]   quot;

    always_comb begin
        // one multiplier shared by the nF and uF ranges
        recip = (ctrl_in.unit == cca_pkg::UNIT_UF) ? cca_pkg::UF_RECIP : cca_pkg::NF_RECIP;
        prod  = cca_pkg::PROD_W'(num) * cca_pkg::PROD_W'(recip);
        case (ctrl_in.unit)
            cca_pkg::UNIT_PF: quot = num[cca_pkg::VAL_W-1:0];
            cca_pkg::UNIT_NF: quot = prod[cca_pkg::NF_SHIFT +: cca_pkg::VAL_W];
            cca_pkg::UNIT_UF: quot = prod[cca_pkg::UF_SHIFT +: cca_pkg::VAL_W];
            default:          quot = '0;
        endcase
        ctrl_next = advance ? ctrl_in : ctrl_reg;
        val_next  = advance ? quot : val_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
        val_reg <= val_next;
    end

    assign ctrl = ctrl_reg;
    assign val  = val_reg;

endmodule

// ----- hdl/cca_digits.sv -----
// decimal digit split and result register
module cca_digits (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  cca_pkg::cca_ctrl_t          ctrl_in,
    input  logic [cca_pkg::VAL_W-1:0]   val,
    output logic                        out_valid,
    output logic [cca_pkg::DIGIT_W-1:0] hundreds,
    output logic [cca_pkg::DIGIT_W-1:0] tens,
    output logic [cca_pkg::DIGIT_W-1:0] ones,
    output logic [1:0]                  unit_code,
    output logic                        in_range
);

    logic                        valid_reg, valid_next;
    logic [cca_pkg::DIGIT_W-1:0] hund_reg, hund_next;
    logic [cca_pkg::DIGIT_W-1:0] tens_reg, tens_next;
    logic [cca_pkg::DIGIT_W-1:0] ones_reg, ones_next;
    logic [1:0]                  unit_reg, unit_next;
    logic                        ok_reg, ok_next;
    logic [cca_pkg::DIGIT_W-1:0] h, t;
    logic [cca_pkg::VAL_W-1:0]   h_base;
    logic [6:0]                  rem, t_base;
    logic [cca_pkg::DIGIT_W-1:0] o;

    always_comb begin
        h      = '0;
        h_base = '0;
        for (int i = 1; i < 10; i++) begin
            if (val >= cca_pkg::VAL_W'(i * 100)) begin
                h      = cca_pkg::DIGIT_W'(i);
                h_base = cca_pkg::VAL_W'(i * 100);
            end
        end
        rem    = 7'(val - h_base);
        t      = '0;
        t_base = '0;
        for (int i = 1; i < 10; i++) begin
            if (rem >= 7'(i * 10)) begin
                t      = cca_pkg::DIGIT_W'(i);
                t_base = 7'(i * 10);
            end
        end
        o = cca_pkg::DIGIT_W'(rem - t_base);

        valid_next = advance ? ctrl_in.valid : valid_reg;
        hund_next  = advance ? h : hund_reg;
        tens_next  = advance ? t : tens_reg;
        ones_next  = advance ? o : ones_reg;
        unit_next  = advance ? ctrl_in.unit : unit_reg;
        ok_next    = advance ? ctrl_in.ok : ok_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        hund_reg <= hund_next;
        tens_reg <= tens_next;
        ones_reg <= ones_next;
        unit_reg <= unit_next;
        ok_reg   <= ok_next;
    end

    assign out_valid = valid_reg;
    assign hundreds  = hund_reg;
    assign tens      = tens_reg;
    assign ones      = ones_reg;
    assign unit_code = unit_reg;
    assign in_range  = ok_reg;

endmodule

// ----- hdl/cca_checker.sv -----
// port checker for the capacitance counter, bound to the top level
module cca_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_digit_hundreds,
    input logic [3:0] m_digit_tens,
    input logic [3:0] m_digit_ones,
    input logic [1:0] m_unit_code,
    input logic       m_in_range
);

    // out of range readings carry zero digits and the pF code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_digit_hundreds == 4'd0 && m_digit_tens == 4'd0
            && m_digit_ones == 4'd0 && m_unit_code == cca_pkg::UNIT_PF)
        else $error("out of range result with nonzero fields");

    // every digit is decimal and the unit code is defined
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit_hundreds <= 4'd9 && m_digit_tens <= 4'd9
            && m_digit_ones <= 4'd9 && m_unit_code != 2'd3)
        else $error("result digit or unit code out of range");

    // pF readings are ticks times 30, so the ones digit is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_range && m_unit_code == cca_pkg::UNIT_PF |-> m_digit_ones == 4'd0)
        else $error("pF reading with nonzero ones digit");

    // input is held off only while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // a stalled result holds its fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_hundreds) && $stable(m_digit_tens)
            && $stable(m_digit_ones) && $stable(m_unit_code) && $stable(m_in_range))
        else $error("stalled result changed");

endmodule

bind capacitance_count_autorange cca_checker u_cca_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_digit_hundreds(m_digit_hundreds),
    .m_digit_tens    (m_digit_tens),
    .m_digit_ones    (m_digit_ones),
    .m_unit_code     (m_unit_code),
    .m_in_range      (m_in_range)
);

// ----- tb/tb.sv -----
// self-checking testbench for capacitance_count_autorange
`timescale 1ns / 100ps

module tb;

    // event kinds on the input channel
    localparam logic KIND_OVERFLOW = 1'b0;
    localparam logic KIND_CAPTURE  = 1'b1;

    // tick arithmetic, kept apart from the package so a wrong constant there shows up
    localparam int              TOTAL_W     = cca_pkg::TOTAL_WIDTH_DEF;
    localparam longint unsigned TOTAL_MAX   = (64'd1 << TOTAL_W) - 1;
    localparam longint unsigned WRAP_TICKS  = 65536;
    localparam longint unsigned PF_TOP      = 34;
    localparam longint unsigned NF_TOP      = 33334;
    localparam longint unsigned UF_TOP      = 33333333;
    localparam longint unsigned PF_FACTOR   = 30;
    localparam longint unsigned RANGE_MULT  = 3;
    localparam longint unsigned NF_DIVISOR  = 100;
    localparam longint unsigned UF_DIVISOR  = 100000;

    // run shape
    localparam int RESET_CYCLES     = 11;
    localparam int DRAIN_CYCLES     = 12;
    localparam int STALL_LIMIT      = 2000;
    localparam int SHORT_PER_PHASE  = 25;
    localparam int REPORT_LIMIT     = 10;
    localparam int SATURATE_WRAPS   = 1030;
    // 508 wraps plus 41045 ticks lands exactly on the out-of-range threshold
    localparam int EDGE_WRAPS       = 508;
    localparam int EDGE_CAPTURE     = 41045;

    // one reading as it leaves the result channel
    typedef struct packed {
        logic [cca_pkg::DIGIT_W-1:0] hundreds;
        logic [cca_pkg::DIGIT_W-1:0] tens;
        logic [cca_pkg::DIGIT_W-1:0] ones;
        cca_pkg::unit_t              unit;
        logic                        in_range;
    } reading_t;

    // tracks the running tick total and the readings still owed by the block
    class reading_tracker;
        longint unsigned ticks_so_far;
        reading_t        readings_due[$];
        int              mismatches;

        function new();
            ticks_so_far = 0;
            mismatches   = 0;
        endfunction

        function void add_ticks(longint unsigned amount);
            longint unsigned sum;
            sum = ticks_so_far + amount;
            ticks_so_far = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;
        endfunction

        // called once per accepted input item
        function void note_event(logic kind, logic [15:0] count);
            reading_t        r;
            longint unsigned t;
            longint unsigned val;
            if (kind == KIND_OVERFLOW) begin
                add_ticks(WRAP_TICKS);
                return;
            end
            add_ticks(count);
            t = ticks_so_far;
            val = 0;
            r.unit = cca_pkg::UNIT_PF;
            r.in_range = 1'b1;
            if (t < PF_TOP) begin
                val = t * PF_FACTOR;
            end else if (t < NF_TOP) begin
                val = (t * RANGE_MULT) / NF_DIVISOR;
                r.unit = cca_pkg::UNIT_NF;
            end else if (t < UF_TOP) begin
                val = (t * RANGE_MULT) / UF_DIVISOR;
                r.unit = cca_pkg::UNIT_UF;
            end else begin
                r.in_range = 1'b0;
            end
            r.hundreds = cca_pkg::DIGIT_W'((val / 100) % 10);
            r.tens     = cca_pkg::DIGIT_W'((val / 10) % 10);
            r.ones     = cca_pkg::DIGIT_W'(val % 10);
            readings_due.push_back(r);
            // a capture always starts a fresh measurement
            ticks_so_far = 0;
        endfunction

        function void report(string what, reading_t want, reading_t seen);
            if (mismatches < REPORT_LIMIT)
                $display({"%0t: %s: expected %0d%0d%0d unit %0d ok %0d, ",
                          "got %0d%0d%0d unit %0d ok %0d"},
                         $realtime, what, want.hundreds, want.tens, want.ones, want.unit,
                         want.in_range, seen.hundreds, seen.tens, seen.ones, seen.unit,
                         seen.in_range);
            mismatches++;
        endfunction

        // called once per accepted result item
        function void check_reading(reading_t seen);
            reading_t want;
            if (readings_due.size() == 0) begin
                report("reading with none outstanding", '0, seen);
                return;
            end
            want = readings_due.pop_front();
            if (seen.hundreds !== want.hundreds || seen.tens !== want.tens ||
                seen.ones !== want.ones || seen.unit !== want.unit ||
                seen.in_range !== want.in_range)
                report("reading mismatch", want, seen);
        endfunction

        function int pending_count();
            return readings_due.size();
        endfunction
    endclass

    logic                         aclk             = 1'b0;
    logic                         aresetn          = 1'b0;
    logic                         s_valid          = 1'b0;
    logic                         s_ready;
    logic                         s_kind           = KIND_OVERFLOW;
    logic [15:0]                  s_captured_count = 16'd0;
    logic                         m_valid;
    logic                         m_ready          = 1'b0;
    logic [cca_pkg::DIGIT_W-1:0]  m_digit_hundreds;
    logic [cca_pkg::DIGIT_W-1:0]  m_digit_tens;
    logic [cca_pkg::DIGIT_W-1:0]  m_digit_ones;
    logic [1:0]                   m_unit_code;
    logic                         m_in_range;

    reading_tracker board = new();

    // idle percentages per phase: none, sender, receiver, both
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;
    int phase_start        = 0;
    int quiet_cycles       = 0;
    int sender_idle_table[4]    = '{0, 73, 0, 29};
    int receiver_stall_table[4] = '{0, 0, 73, 29};

    capacitance_count_autorange uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_captured_count (s_captured_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digit_hundreds (m_digit_hundreds),
        .m_digit_tens     (m_digit_tens),
        .m_digit_ones     (m_digit_ones),
        .m_unit_code      (m_unit_code),
        .m_in_range       (m_in_range)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // result side: random back-pressure, check every accepted reading
    // handshake signals are read right at the edge, before any flop updates
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_reading({m_digit_hundreds, m_digit_tens, m_digit_ones,
                                 cca_pkg::unit_t'(m_unit_code), m_in_range});
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: too long without any handshake on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("capacitance_count_autorange verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item, with random idle cycles ahead of it, and wait for acceptance
    // valid is written at most once per edge so it never drops between back-to-back items
    task automatic send_event(input logic kind, input logic [15:0] count);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_kind           <= kind;
        s_captured_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_event(kind, count);
        items_sent++;
    endtask

    // a long string of timer wraps then the capture that ends it
    task automatic run_long_reading(input int wraps, input logic [15:0] count);
        for (int i = 0; i < wraps; i++)
            send_event(KIND_OVERFLOW, 16'($urandom));
        send_event(KIND_CAPTURE, count);
    endtask

    // a typical measurement: a few wraps, capture value biased toward range edges
    task automatic run_short_reading();
        int          wraps;
        int          pick;
        logic [15:0] count;
        pick = $urandom_range(99);
        if (pick < 60)
            wraps = 0;
        else if (pick < 85)
            wraps = 1;
        else if (pick < 95)
            wraps = $urandom_range(4, 2);
        else
            wraps = $urandom_range(20, 5);
        // captured value rides along on wraps too and must be ignored there
        for (int i = 0; i < wraps; i++)
            send_event(KIND_OVERFLOW, 16'($urandom));
        case ($urandom_range(4))
            0: count = 16'($urandom_range(40));
            1: count = 16'($urandom_range(37, 30));
            2: count = 16'($urandom_range(33340, 33328));
            3: count = 16'($urandom_range(65535, 65500));
            default: count = 16'($urandom);
        endcase
        send_event(KIND_CAPTURE, count);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: range edges, digit extremes, wraps carrying noise
        send_event(KIND_CAPTURE, 16'd0);
        send_event(KIND_CAPTURE, 16'd1);
        send_event(KIND_CAPTURE, 16'd33);
        send_event(KIND_CAPTURE, 16'd34);
        send_event(KIND_CAPTURE, 16'd33333);
        send_event(KIND_CAPTURE, 16'd33334);
        send_event(KIND_CAPTURE, 16'hFFFF);
        send_event(KIND_OVERFLOW, 16'hFFFF);
        send_event(KIND_CAPTURE, 16'd0);
        send_event(KIND_OVERFLOW, 16'h5A5A);
        send_event(KIND_CAPTURE, 16'hFFFF);
        send_event(KIND_OVERFLOW, 16'h0000);
        send_event(KIND_OVERFLOW, 16'hA5A5);
        send_event(KIND_CAPTURE, 16'd12345);
        send_event(KIND_CAPTURE, 16'd17);
        send_event(KIND_CAPTURE, 16'd100);

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = sender_idle_table[phase];
            receiver_stall_pct = receiver_stall_table[phase];
            // saturating total, then a reading exactly at the out-of-range edge
            if (phase == 1)
                run_long_reading(SATURATE_WRAPS, 16'($urandom));
            if (phase == 2)
                run_long_reading(EDGE_WRAPS, 16'(EDGE_CAPTURE));
            phase_start = items_sent;
            while (items_sent - phase_start < SHORT_PER_PHASE)
                run_short_reading();
        end
        s_valid <= 1'b0;

        // let the pipeline empty, then a few more cycles for anything stray
        while (board.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.pending_count() == 0)
            $display("capacitance_count_autorange verification clean");
        else
            $display("capacitance_count_autorange verification failed");
        $finish;
    end

endmodule
